>>> rtl/core/tmwd_pkg.sv
// Shared widths, reset values, compass codes and lane control type for the wall detector.
`timescale 1ns / 1ps

package tmwd_pkg;

	localparam int DIST_W      = 10;
	localparam int HEAD_W      = 4;
	localparam int SAMPLES_DEF = 5;
	localparam int LANES       = 3;
	localparam int DATA_IN_W   = 40;
	localparam int DATA_OUT_W  = 40;

	localparam logic [DIST_W-1:0] THR_RESET = 10'd17;
	localparam logic [DIST_W-1:0] DIST_MAX  = 10'h3FF;

	localparam logic [HEAD_W-1:0] DIR_N = 4'd1;
	localparam logic [HEAD_W-1:0] DIR_E = 4'd2;
	localparam logic [HEAD_W-1:0] DIR_S = 4'd4;
	localparam logic [HEAD_W-1:0] DIR_W = 4'd8;

	localparam int LANE_L = 0;
	localparam int LANE_R = 1;
	localparam int LANE_F = 2;

	typedef struct packed {
		logic acc_en;
		logic last;
		logic en1;
		logic en2;
		logic en3;
	} tmwd_ctrl_t;

endpackage

>>> rtl/core/tmwd_lane.sv
// One sensor lane: running sum/max/min and the trimmed mean divider pipeline.
`timescale 1ns / 1ps

module tmwd_lane #(
	parameter int SAMPLES_PER_CHECK = tmwd_pkg::SAMPLES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tmwd_pkg::tmwd_ctrl_t        ctrl,
	input  logic [tmwd_pkg::DIST_W-1:0] sample,
	output logic [tmwd_pkg::DIST_W-1:0] dist_s3
);
	import tmwd_pkg::*;

	localparam int SUM_W  = $clog2(SAMPLES_PER_CHECK * 1023 + 1);
	localparam int DIV    = SAMPLES_PER_CHECK - 2;
	localparam int K      = SUM_W + 1;
	localparam int M_W    = K + 1;
	localparam int PROD_W = SUM_W + M_W;
	localparam logic [M_W-1:0]   RECIP   = M_W'((2 ** K) / DIV);
	localparam logic [SUM_W-1:0] DIV_V   = SUM_W'(DIV);

	logic [SUM_W-1:0]  sum_q;
	logic [DIST_W-1:0] max_q;
	logic [DIST_W-1:0] min_q;
	logic [SUM_W-1:0]  sum_nx;
	logic [DIST_W-1:0] max_nx;
	logic [DIST_W-1:0] min_nx;
	logic [SUM_W-1:0]  rest_s1;
	logic [SUM_W-1:0]  rest_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [DIST_W-1:0] q0;
	logic [SUM_W-1:0]  rem;

	assign sum_nx = sum_q + SUM_W'(sample);
	assign max_nx = (sample > max_q) ? sample : max_q;
	assign min_nx = (sample < min_q) ? sample : min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			max_q <= '0;
			min_q <= DIST_MAX;
		end else if (ctrl.acc_en) begin
			if (ctrl.last) begin
				sum_q <= '0;
				max_q <= '0;
				min_q <= DIST_MAX;
			end else begin
				sum_q <= sum_nx;
				max_q <= max_nx;
				min_q <= min_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en1) begin
			rest_s1 <= sum_nx - SUM_W'(max_nx) - SUM_W'(min_nx);
		end
		if (ctrl.en2) begin
			rest_s2 <= rest_s1;
			prod_s2 <= PROD_W'(rest_s1) * PROD_W'(RECIP);
		end
		if (ctrl.en3) begin
			dist_s3 <= q0 + DIST_W'(rem >= DIV_V);
		end
	end

	// reciprocal estimate is exact or one low
	assign q0  = prod_s2[K +: DIST_W];
	assign rem = rest_s2 - SUM_W'(SUM_W'(q0) * DIV_V);

endmodule

>>> rtl/core/tmwd_merge.sv
// Threshold register, compass mapping of the lane results and the output register.
`timescale 1ns / 1ps

module tmwd_merge (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tmwd_pkg::DIST_W-1:0]     cfg_wdata,
	input  logic                            valid_s3,
	input  logic [tmwd_pkg::HEAD_W-1:0]     heading_s3,
	input  logic [tmwd_pkg::DIST_W-1:0]     dist_s3 [tmwd_pkg::LANES],
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tmwd_pkg::DATA_OUT_W-1:0] m_tdata
);
	import tmwd_pkg::*;

	logic [DIST_W-1:0] thr_q;
	logic              lw;
	logic              rw;
	logic              fw;
	logic [HEAD_W-1:0] walls;
	logic              rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign lw = dist_s3[LANE_L] <= thr_q;
	assign rw = dist_s3[LANE_R] <= thr_q;
	assign fw = dist_s3[LANE_F] <= thr_q;

	always_comb begin
		case (heading_s3)
			DIR_N:   walls = (lw ? DIR_W : '0) | (rw ? DIR_E : '0) | (fw ? DIR_N : '0);
			DIR_E:   walls = (lw ? DIR_N : '0) | (rw ? DIR_S : '0) | (fw ? DIR_E : '0);
			DIR_S:   walls = (lw ? DIR_E : '0) | (rw ? DIR_W : '0) | (fw ? DIR_S : '0);
			DIR_W:   walls = (lw ? DIR_S : '0) | (rw ? DIR_N : '0) | (fw ? DIR_W : '0);
			default: walls = '0;
		endcase
	end

	assign rdy4 = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (rdy4) begin
			m_tvalid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			m_tdata <= {6'd0, dist_s3[LANE_F], dist_s3[LANE_R], dist_s3[LANE_L], walls};
		end
	end

endmodule

>>> rtl/core/trimmed_mean_wall_detector.sv
// Top level of the trimmed mean wall detector: round counter, lanes and merge.
//
// Usage:
//   s_* carries one reading per sensor plus the heading on every transfer.
//   Every SAMPLES_PER_CHECK-th transfer closes a group: each lane drops the
//   largest and smallest reading, divides the rest by SAMPLES_PER_CHECK-2
//   and m_* then presents one result with compass wall bits and distances.
//   Other transfers give no result. wall_threshold is written on cfg_we.
// Throughput: one input transfer per cycle, sustained while the output is not stalled.
// Pipeline: after the closing transfer a result passes the lane stages rest,
//   reciprocal multiply and correction, then the output register that drives m_tvalid.
// Reset: arst_n clears counters, accumulators, pipeline valids and sets
//   the threshold to 17; no clearing pass is needed.
// Stall: a held result waits in the output register; the three pipeline
//   stages fill behind it, and s_tready drops only for a closing transfer
//   that finds all stages full. Non-closing transfers are always taken.
`timescale 1ns / 1ps

module trimmed_mean_wall_detector #(
	parameter int SAMPLES_PER_CHECK = tmwd_pkg::SAMPLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tmwd_pkg::DIST_W-1:0]     cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// left_sample[9:0], right_sample[19:10], front_sample[29:20], heading[33:30]
	input  logic [tmwd_pkg::DATA_IN_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cell_walls[3:0], left_distance[13:4], right_distance[23:14], front_distance[33:24]
	output logic [tmwd_pkg::DATA_OUT_W-1:0] m_tdata
);
	import tmwd_pkg::*;

	localparam int CNT_W = $clog2(SAMPLES_PER_CHECK);
	localparam logic [CNT_W-1:0] LAST_RND = CNT_W'(SAMPLES_PER_CHECK - 1);

	logic [CNT_W-1:0]  round_q;
	logic              last;
	logic              fire;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic [HEAD_W-1:0] heading_s1;
	logic [HEAD_W-1:0] heading_s2;
	logic [HEAD_W-1:0] heading_s3;
	logic              rdy1;
	logic              rdy2;
	logic              rdy3;
	logic              rdy4;
	tmwd_ctrl_t        ctrl;
	logic [DIST_W-1:0] sample [LANES];
	logic [DIST_W-1:0] dist_s3 [LANES];

	assign last     = round_q == LAST_RND;
	assign rdy4     = !m_tvalid || m_tready;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign s_tready = !last || rdy1;
	assign fire     = s_tvalid && s_tready;

	assign ctrl.acc_en = fire;
	assign ctrl.last   = last;
	assign ctrl.en1    = fire && last;
	assign ctrl.en2    = rdy2 && valid_s1;
	assign ctrl.en3    = rdy3 && valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (fire) begin
				round_q <= last ? '0 : round_q + CNT_W'(1);
			end
			if (rdy1) begin
				valid_s1 <= fire && last;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en1) begin
			heading_s1 <= s_tdata[3*DIST_W +: HEAD_W];
		end
		if (ctrl.en2) begin
			heading_s2 <= heading_s1;
		end
		if (ctrl.en3) begin
			heading_s3 <= heading_s2;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		assign sample[i] = s_tdata[i*DIST_W +: DIST_W];

		tmwd_lane #(
			.SAMPLES_PER_CHECK(SAMPLES_PER_CHECK)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.sample (sample[i]),
			.dist_s3(dist_s3[i])
		);
	end

	tmwd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s3  (valid_s3),
		.heading_s3(heading_s3),
		.dist_s3   (dist_s3),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

>>> rtl/core/tmwd_checker.sv
// Port-level checks for the wall detector and their bind to the top level.
`timescale 1ns / 1ps

module tmwd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tmwd_pkg::DATA_OUT_W-1:0] m_tdata
);
	import tmwd_pkg::*;

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input backs up only behind a stalled output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// the wall behind the robot is never reported
	a_behind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(m_tdata[HEAD_W-1:0]) <= 3)
		else $error("four walls reported");

	// padding stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[DATA_OUT_W-1:HEAD_W+3*DIST_W] == '0)
		else $error("nonzero padding in result");

endmodule

bind trimmed_mean_wall_detector tmwd_checker u_tmwd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
